@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational check at every edge
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent this edge, consequent next edge
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/q2e_pkg.sv @@
// ---------------------------------------------------------------------------
// q2e_pkg
// Widths, constants, arctangent table and pipeline payload types.
// ---------------------------------------------------------------------------
package q2e_pkg;

  localparam int TW = 34;  // sine / cosine terms, Q28
  localparam int XW = 37;  // CORDIC x / y
  localparam int ZW = 36;  // CORDIC angle, Q30
  localparam int RW = 57;  // square root remainder
  localparam int SW = 29;  // square root result
  localparam int SQ_STAGES = 29;
  localparam int ATAN_LEN = 24;

  localparam logic signed [TW-1:0] ONE_Q28    = 34'sd268435456;
  localparam logic signed [ZW-1:0] PI_Q30     = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam int PI_Q12     = 12868;
  localparam int TWO_PI_Q12 = 25736;

  localparam logic [29:0] ATAN_TAB [ATAN_LEN] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256, 30'd128
  };

  typedef enum logic [2:0] {
    PM_NORM = 3'b001,
    PM_HIGH = 3'b010,
    PM_LOW  = 3'b100
  } q2e_pmode_t;

  typedef struct packed {
    logic signed [TW-1:0] sinr;
    logic signed [TW-1:0] cosr;
    logic signed [TW-1:0] sinp;
    logic signed [TW-1:0] siny;
    logic signed [TW-1:0] cosy;
    q2e_pmode_t           pmode;
    logic [RW-1:0]        rem;
    logic [SW-1:0]        root;
  } q2e_sq_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } q2e_vec_t;

  typedef struct packed {
    q2e_vec_t   roll;
    q2e_vec_t   pitch;
    q2e_vec_t   yaw;
    q2e_pmode_t pmode;
  } q2e_rot_t;

endpackage

@@ rtl/q2e_sqrt_cell.sv @@
// ---------------------------------------------------------------------------
// q2e_sqrt_cell
// One result bit of the digit-by-digit square root, with its own stage.
// ---------------------------------------------------------------------------
module q2e_sqrt_cell import q2e_pkg::*; #(
  parameter int K = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    valid_i,
  input  q2e_sq_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  output q2e_sq_t data_o,
  input  logic    ready_i
);

  logic    valid_r;
  q2e_sq_t data_r, data_nxt;
  logic [RW+1:0] trial;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  always_comb begin
    data_nxt = data_i;
    trial = ((RW+2)'(data_i.root) << (K + 1)) + ((RW+2)'(1) << (2 * K));
    if ((RW+2)'(data_i.rem) >= trial) begin
      data_nxt.rem  = data_i.rem - RW'(trial);
      data_nxt.root = data_i.root | (SW'(1) << K);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ rtl/q2e_cordic_cell.sv @@
// ---------------------------------------------------------------------------
// q2e_cordic_cell
// One CORDIC vectoring iteration for the roll, pitch and yaw vectors.
// ---------------------------------------------------------------------------
module q2e_cordic_cell import q2e_pkg::*; #(
  parameter int I = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     valid_i,
  input  q2e_rot_t data_i,
  output logic     ready_o,
  output logic     valid_o,
  output q2e_rot_t data_o,
  input  logic     ready_i
);

  logic     valid_r;
  q2e_rot_t data_r, data_nxt;

  function automatic q2e_vec_t rotate(q2e_vec_t v);
    q2e_vec_t r;
    logic signed [XW-1:0] dx, dy;
    r  = v;
    dx = $signed(v.x) >>> I;
    dy = $signed(v.y) >>> I;
    if (!v.y[XW-1]) begin
      r.x = v.x + dy;
      r.y = v.y - dx;
      r.z = v.z + ZW'(ATAN_TAB[I]);
    end else begin
      r.x = v.x - dy;
      r.y = v.y + dx;
      r.z = v.z - ZW'(ATAN_TAB[I]);
    end
    return r;
  endfunction

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  always_comb begin
    data_nxt       = data_i;
    data_nxt.roll  = rotate(data_i.roll);
    data_nxt.pitch = rotate(data_i.pitch);
    data_nxt.yaw   = rotate(data_i.yaw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ rtl/quaternion_to_euler_angles_unit.sv @@
// ---------------------------------------------------------------------------
// quaternion_to_euler_angles_unit
// Unit quaternion (Q2.14) to roll, pitch, yaw (Q4.12) through a chain of
// square root and CORDIC cells.
// ---------------------------------------------------------------------------
// channel  dir  tdata fields (low bit up)
// in_      in   quat_x[15:0] quat_y[31:16] quat_z[47:32] quat_w[63:48]
// out_     out  roll_angle[14:0] pitch_angle[28:15] yaw_angle[43:29], 0 pad
//
// One item per cycle sustained while the output is not stalled; stages in order:
// 3 product/sum stages, 29 square root cells, prep, CORDIC cells, output.
// Every stage has its own valid bit; reset clears them all.
// A stalled output holds only the stages that are full; bubbles close up.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_to_euler_angles_unit import q2e_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // quat_x, quat_y, quat_z, quat_w
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // roll_angle, pitch_angle, yaw_angle, pad
);

  localparam int NC = CORDIC_STAGES;

  typedef struct packed {
    logic signed [31:0] wx, yz, xx, yy, wy, zx, wz, xy, zz;
  } q2e_prod_t;

  // stage A: products
  logic      a_valid_r, a_ready;
  q2e_prod_t a_r, a_nxt;
  // stage B: terms
  logic      b_valid_r, b_ready;
  q2e_sq_t   b_r, b_nxt;
  // stage C: square root radicand
  logic      c_valid_r, c_ready;
  q2e_sq_t   c_r, c_nxt;
  // prep stage
  logic      p_valid_r, p_ready;
  q2e_rot_t  p_r, p_nxt;
  // output stage
  logic        f_valid_r, f_ready;
  logic [47:0] f_r, f_nxt;

  logic    sq_valid [SQ_STAGES+1];
  logic    sq_ready [SQ_STAGES+1];
  q2e_sq_t sq_data  [SQ_STAGES+1];
  logic     cv_valid [NC+1];
  logic     cv_ready [NC+1];
  q2e_rot_t cv_data  [NC+1];

  logic signed [15:0] qx, qy, qz, qw;
  assign qx = $signed(in_tdata[15:0]);
  assign qy = $signed(in_tdata[31:16]);
  assign qz = $signed(in_tdata[47:32]);
  assign qw = $signed(in_tdata[63:48]);

  assign a_ready   = !a_valid_r || b_ready;
  assign b_ready   = !b_valid_r || c_ready;
  assign c_ready   = !c_valid_r || sq_ready[0];
  assign p_ready   = !p_valid_r || cv_ready[0];
  assign f_ready   = !f_valid_r || out_tready;
  assign in_tready = a_ready;

  always_comb begin
    a_nxt.wx = qw * qx;
    a_nxt.yz = qy * qz;
    a_nxt.xx = qx * qx;
    a_nxt.yy = qy * qy;
    a_nxt.wy = qw * qy;
    a_nxt.zx = qz * qx;
    a_nxt.wz = qw * qz;
    a_nxt.xy = qx * qy;
    a_nxt.zz = qz * qz;
  end

  always_comb begin
    b_nxt      = '0;
    b_nxt.sinr = TW'(2 * (TW'(a_r.wx) + TW'(a_r.yz)));
    b_nxt.cosr = ONE_Q28 - TW'(2 * (TW'(a_r.xx) + TW'(a_r.yy)));
    b_nxt.sinp = TW'(2 * (TW'(a_r.wy) + TW'(a_r.zx)));
    b_nxt.siny = TW'(2 * (TW'(a_r.wz) + TW'(a_r.xy)));
    b_nxt.cosy = ONE_Q28 - TW'(2 * (TW'(a_r.yy) + TW'(a_r.zz)));
    if (b_nxt.sinp >= ONE_Q28) begin
      b_nxt.pmode = PM_HIGH;
    end else if (b_nxt.sinp <= -ONE_Q28) begin
      b_nxt.pmode = PM_LOW;
    end else begin
      b_nxt.pmode = PM_NORM;
    end
  end

  logic signed [SW-1:0] s29;
  logic signed [RW:0]   sinp_sq;
  always_comb begin
    s29     = $signed(b_r.sinp[SW-1:0]);
    sinp_sq = s29 * s29;
    c_nxt   = b_r;
    c_nxt.root = '0;
    if (b_r.pmode == PM_NORM) begin
      c_nxt.rem = RW'(((RW+1)'(1) << (RW - 1)) - sinp_sq);
    end else begin
      c_nxt.rem = '0;
    end
  end

  function automatic q2e_vec_t prep(logic signed [XW-1:0] y, logic signed [XW-1:0] x);
    q2e_vec_t v;
    v.zero = (x == '0) && (y == '0);
    if (x[XW-1]) begin
      v.x = -x;
      v.y = -y;
      v.z = y[XW-1] ? -PI_Q30 : PI_Q30;
    end else begin
      v.x = x;
      v.y = y;
      v.z = '0;
    end
    return v;
  endfunction

  always_comb begin
    p_nxt.roll  = prep(XW'(sq_data[SQ_STAGES].sinr), XW'(sq_data[SQ_STAGES].cosr));
    p_nxt.pitch = prep(XW'(sq_data[SQ_STAGES].sinp),
                       $signed(XW'(sq_data[SQ_STAGES].root)));
    p_nxt.yaw   = prep(XW'(sq_data[SQ_STAGES].siny), XW'(sq_data[SQ_STAGES].cosy));
    p_nxt.pmode = sq_data[SQ_STAGES].pmode;
  end

  function automatic logic signed [ZW+1:0] to_q12(logic signed [ZW+1:0] v);
    return (v + (ZW+2)'(131072)) >>> 18;
  endfunction

  function automatic logic signed [ZW+1:0] angle(q2e_vec_t v);
    return v.zero ? '0 : (ZW+2)'(v.z);
  endfunction

  logic signed [ZW+1:0] ra, pa, ya;
  logic [14:0] roll_q;
  logic [13:0] pitch_q;
  logic [14:0] yaw_q;
  always_comb begin
    ra = to_q12(angle(cv_data[NC].roll));
    case (cv_data[NC].pmode)
      PM_HIGH: pa = (ZW+2)'(PI_Q30);
      PM_LOW:  pa = '0;
      default: pa = angle(cv_data[NC].pitch) + (ZW+2)'(HALF_PI_Q30);
    endcase
    pa = to_q12(pa);
    ya = to_q12(angle(cv_data[NC].yaw) + (ZW+2)'(PI_Q30));
    if (ra > (ZW+2)'(PI_Q12)) begin
      roll_q = 15'(PI_Q12);
    end else if (ra < -(ZW+2)'(PI_Q12)) begin
      roll_q = 15'(-PI_Q12);
    end else begin
      roll_q = ra[14:0];
    end
    if (pa > (ZW+2)'(PI_Q12)) begin
      pitch_q = 14'(PI_Q12);
    end else if (pa[ZW+1]) begin
      pitch_q = '0;
    end else begin
      pitch_q = pa[13:0];
    end
    if (ya > (ZW+2)'(TWO_PI_Q12)) begin
      yaw_q = 15'(TWO_PI_Q12);
    end else if (ya[ZW+1]) begin
      yaw_q = '0;
    end else begin
      yaw_q = ya[14:0];
    end
    f_nxt = {4'b0, yaw_q, pitch_q, roll_q};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      p_valid_r <= 1'b0;
      f_valid_r <= 1'b0;
    end else begin
      if (a_ready) a_valid_r <= in_tvalid;
      if (b_ready) b_valid_r <= a_valid_r;
      if (c_ready) c_valid_r <= b_valid_r;
      if (p_ready) p_valid_r <= sq_valid[SQ_STAGES];
      if (f_ready) f_valid_r <= cv_valid[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_tvalid) a_r <= a_nxt;
    if (b_ready && a_valid_r) b_r <= b_nxt;
    if (c_ready && b_valid_r) c_r <= c_nxt;
    if (p_ready && sq_valid[SQ_STAGES]) p_r <= p_nxt;
    if (f_ready && cv_valid[NC]) f_r <= f_nxt;
  end

  assign sq_valid[0]         = c_valid_r;
  assign sq_data[0]          = c_r;
  assign sq_ready[SQ_STAGES] = p_ready;
  assign cv_valid[0]         = p_valid_r;
  assign cv_data[0]          = p_r;
  assign cv_ready[NC]        = f_ready;

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
    q2e_sqrt_cell #(.K(SQ_STAGES - 1 - j)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (sq_valid[j]),
      .data_i  (sq_data[j]),
      .ready_o (sq_ready[j]),
      .valid_o (sq_valid[j+1]),
      .data_o  (sq_data[j+1]),
      .ready_i (sq_ready[j+1])
    );
  end

  for (genvar j = 0; j < NC; j++) begin : g_cordic
    q2e_cordic_cell #(.I(j)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (cv_valid[j]),
      .data_i  (cv_data[j]),
      .ready_o (cv_ready[j]),
      .valid_o (cv_valid[j+1]),
      .data_o  (cv_data[j+1]),
      .ready_i (cv_ready[j+1])
    );
  end

  assign out_tvalid = f_valid_r;
  assign out_tdata  = f_r;

  `ASSERT_ALWAYS(a_in_stall_full, in_tready || a_valid_r, "input stalled with stage A empty")
  `ASSERT_NEXT(a_pitch_sat, cv_valid[NC] && f_ready && cv_data[NC].pmode == PM_HIGH, out_tdata[28:15] == 14'(PI_Q12), "saturated pitch not pi")
  `ASSERT_ALWAYS(a_yaw_range, !out_tvalid || out_tdata[43:29] <= 15'(TWO_PI_Q12), "yaw out of range")

endmodule

@@ bench/tb_quaternion_to_euler_angles_unit.sv @@
// ---------------------------------------------------------------------------
// tb_quaternion_to_euler_angles_unit
// Streams quaternions through the converter and compares every result with
// an in-bench CORDIC predictor of roll, pitch and yaw, field by field.
// ---------------------------------------------------------------------------
module tb_quaternion_to_euler_angles_unit;
  import q2e_pkg::*;

  localparam int STAGES = 16;
  localparam int LAT = 34 + STAGES;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [14:0] yaw;
    logic [13:0] pitch;
    logic signed [14:0] roll;
  } angles_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [47:0] out_tdata;

  angles_t angles_due[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int sink_wait = 0;
  bit hold_sink = 0;
  bit sending_done = 0;

  quaternion_to_euler_angles_unit #(.CORDIC_STAGES(STAGES)) uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint vector_angle(longint sy, longint cx);
    longint off, z, dx, dy;
    off = 0;
    z = 0;
    if (cx == 0 && sy == 0) return 0;
    if (cx < 0) begin
      off = (sy >= 0) ? PI_Q30 : -PI_Q30;
      cx = -cx;
      sy = -sy;
    end
    for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
      dx = floor_shift(cx, i);
      dy = floor_shift(sy, i);
      if (sy >= 0) begin
        cx += dy;
        sy -= dx;
        z += longint'(ATAN_TAB[i]);
      end else begin
        cx -= dy;
        sy += dx;
        z -= longint'(ATAN_TAB[i]);
      end
    end
    return off + z;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint to_q12(longint v, longint lo, longint hi);
    longint r;
    r = floor_shift(v + (64'sd1 <<< 17), 18);
    return (r < lo) ? lo : ((r > hi) ? hi : r);
  endfunction

  function automatic angles_t euler_of(logic [63:0] q);
    longint x, y, z, w, sr, cr, sp, sy, cy, p, one;
    angles_t a;
    one = 64'sd1 <<< 28;
    x = longint'($signed(q[15:0]));
    y = longint'($signed(q[31:16]));
    z = longint'($signed(q[47:32]));
    w = longint'($signed(q[63:48]));
    sr = 2 * (w * x + y * z);
    cr = one - 2 * (x * x + y * y);
    sp = 2 * (w * y + z * x);
    sy = 2 * (w * z + x * y);
    cy = one - 2 * (y * y + z * z);
    a.roll = 15'(to_q12(vector_angle(sr, cr), -PI_Q12, PI_Q12));
    if (sp >= one) p = PI_Q30;
    else if (sp <= -one) p = 0;
    else p = vector_angle(sp, int_sqrt((64'd1 << 56) - longint'(sp * sp))) + HALF_PI_Q30;
    a.pitch = 14'(to_q12(p, 0, PI_Q12));
    a.yaw = 15'(to_q12(vector_angle(sy, cy) + PI_Q30, 0, TWO_PI_Q12));
    return a;
  endfunction

  task automatic send_quat(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                           logic [15:0] w);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 1)) gap = 0;
    if (gap != 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {w, z, y, x};
    angles_due.push_back(euler_of({w, z, y, x}));
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    in_tvalid <= 0;
    while (angles_due.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_comp();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic test_directed();
    logic [15:0] v [7];
    v = '{16'sd16384, -16'sd16384, 16'sd0, 16'sd11585, -16'sd11585, 16'h7fff, 16'h8000};
    send_quat(16'd0, 16'd0, 16'd0, 16'd16384);
    send_quat(16'd0, 16'd0, 16'd0, 16'd0);
    send_quat(16'd16384, 16'd0, 16'd0, 16'd0);
    send_quat(16'd0, 16'd16384, 16'd0, 16'd0);
    send_quat(16'd0, 16'd0, 16'd16384, 16'd0);
    send_quat(16'd0, 16'd11585, 16'd0, 16'd11585);
    send_quat(16'd0, -16'sd11585, 16'd0, 16'd11585);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_quat(16'hffff, 16'h5555, 16'haaaa, 16'h0001);
    for (int i = 0; i < 10; i++)
      send_quat(v[$urandom_range(0, 6)], v[$urandom_range(0, 6)],
                v[$urandom_range(0, 6)], v[$urandom_range(0, 6)]);
  endtask

  task automatic test_unit_random(int n);
    real a, b, c, d, m;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        a = real'($signed(rand_comp())); b = real'($signed(rand_comp()));
        c = real'($signed(rand_comp())); d = real'($signed(rand_comp()));
        m = $sqrt(a * a + b * b + c * c + d * d);
        if (m < 1.0) m = 1.0;
        send_quat(16'($rtoi(a * 16384.0 / m)), 16'($rtoi(b * 16384.0 / m)),
                  16'($rtoi(c * 16384.0 / m)), 16'($rtoi(d * 16384.0 / m)));
      end
    end
  endtask

  task automatic test_backpressure();
    hold_sink = 1;
    for (int i = 0; i < 80; i++) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    wait_drained();
  endtask

  // random per-item sink wait after each accepted result
  always @(posedge clk) begin
    int w;
    if (!rst_n || hold_sink) begin
      out_tready <= 0;
      sink_wait <= 0;
    end else if (sink_wait != 0) begin
      out_tready <= 0;
      sink_wait <= sink_wait - 1;
    end else if (out_tvalid && out_tready) begin
      w = ($urandom_range(0, 1) == 1) ? 0 : int'($urandom_range(0, 14));
      out_tready <= (w == 0);
      sink_wait <= (w == 0) ? 0 : w - 1;
    end else begin
      out_tready <= 1;
    end
  end

  initial begin : sink_release
    @(posedge hold_sink);
    repeat (300) @(posedge clk);
    hold_sink = 0;
  end

  always @(posedge clk) begin
    angles_t got, want;
    if (rst_n && (in_tvalid && in_tready || out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = angles_t'(out_tdata[43:0]);
      if (angles_due.size() == 0 || out_tdata[47:44] != 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        if (angles_due.size() != 0) void'(angles_due.pop_front());
      end else begin
        want = angles_due.pop_front();
        if (got.roll != want.roll || got.pitch != want.pitch || got.yaw != want.yaw) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch roll %0d/%0d pitch %0d/%0d yaw %0d/%0d (exp/got)",
                     want.roll, got.roll, want.pitch, got.pitch, want.yaw, got.yaw);
        end
      end
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    test_directed();
    wait_drained();
    test_unit_random(200);
    test_backpressure();
    test_unit_random(200);
    wait_drained();
    if (mismatches == 0 && angles_due.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
